[src/tach_pkg.sv]
// shared types, constants and microcode program of the rpm statistics tachometer
package tach_pkg;

    // statistics widths
    localparam int COUNT_WIDTH = 24;
    localparam int RPM_W       = 16;
    localparam int TOTAL_W     = COUNT_WIDTH + RPM_W;
    localparam int TS_W        = 32;
    localparam int BLADE_W     = 8;
    localparam int DIV_W       = 32;
    localparam int ITER_W      = $clog2(TOTAL_W + 1);
    localparam int UPC_W       = 4;

    localparam logic [RPM_W-1:0]       RPM_NUMERATOR = RPM_W'(60000);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = {COUNT_WIDTH{1'b1}};
    localparam logic [ITER_W-1:0]      ITER_RPM      = ITER_W'(RPM_W);
    localparam logic [ITER_W-1:0]      ITER_AVG      = ITER_W'(TOTAL_W);
    localparam logic [BLADE_W-1:0]     BLADE_RESET   = BLADE_W'(1);

    // command codes of an input beat
    typedef enum logic [1:0] {
        OP_EDGE   = 2'd0,
        OP_READ   = 2'd1,
        OP_START  = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    // datapath actions of one microcode step
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD_RPM,
        ACT_LOAD_BLADE,
        ACT_LOAD_AVG,
        ACT_DIV_STEP,
        ACT_ACCUM,
        ACT_EDGE_TIME,
        ACT_START,
        ACT_EMIT_AVG,
        ACT_EMIT_ZERO
    } t_act;

    // jump conditions
    typedef enum logic [1:0] {
        CND_NEXT,
        CND_NO_PREV,
        CND_COUNT_ZERO,
        CND_ITER_MORE
    } t_cond;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } t_seq_state;

    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  target;
        logic  last;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic have_prev;
        logic count_zero;
        logic out_busy;
    } t_seq_status;

    // sequencer commands to the datapath
    typedef struct packed {
        t_act act;
        logic busy;
    } t_seq_ctrl;

    // divider controls
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    // program addresses
    localparam t_upc UA_EDGE   = UPC_W'(0);
    localparam t_upc UA_BLDIV  = UPC_W'(2);
    localparam t_upc UA_BLDIV2 = UPC_W'(4);
    localparam t_upc UA_REC    = UPC_W'(6);
    localparam t_upc UA_READ   = UPC_W'(7);
    localparam t_upc UA_AVGDIV = UPC_W'(9);
    localparam t_upc UA_RZERO  = UPC_W'(11);
    localparam t_upc UA_START  = UPC_W'(12);
    localparam t_upc UA_IGNORE = UPC_W'(13);

    // microcode program
    function automatic t_uword ucode_rom(t_upc pc);
        t_uword w;
        w = '{act: ACT_NONE, cond: CND_NEXT, target: UA_EDGE, last: 1'b1};
        case (pc)
            UPC_W'(0):  w = '{act: ACT_NONE,       cond: CND_NO_PREV,    target: UA_REC,
                              last: 1'b0};
            UPC_W'(1):  w = '{act: ACT_LOAD_RPM,   cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b0};
            UPC_W'(2):  w = '{act: ACT_DIV_STEP,   cond: CND_ITER_MORE,  target: UA_BLDIV,
                              last: 1'b0};
            UPC_W'(3):  w = '{act: ACT_LOAD_BLADE, cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b0};
            UPC_W'(4):  w = '{act: ACT_DIV_STEP,   cond: CND_ITER_MORE,  target: UA_BLDIV2,
                              last: 1'b0};
            UPC_W'(5):  w = '{act: ACT_ACCUM,      cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b0};
            UPC_W'(6):  w = '{act: ACT_EDGE_TIME,  cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b1};
            UPC_W'(7):  w = '{act: ACT_NONE,       cond: CND_COUNT_ZERO, target: UA_RZERO,
                              last: 1'b0};
            UPC_W'(8):  w = '{act: ACT_LOAD_AVG,   cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b0};
            UPC_W'(9):  w = '{act: ACT_DIV_STEP,   cond: CND_ITER_MORE,  target: UA_AVGDIV,
                              last: 1'b0};
            UPC_W'(10): w = '{act: ACT_EMIT_AVG,   cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b1};
            UPC_W'(11): w = '{act: ACT_EMIT_ZERO,  cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b1};
            UPC_W'(12): w = '{act: ACT_START,      cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b1};
            default:    w = '{act: ACT_NONE,       cond: CND_NEXT,       target: UA_EDGE,
                              last: 1'b1};
        endcase
        return w;
    endfunction

    // entry point of each command
    function automatic t_upc op_entry(t_opcode op);
        t_upc pc;
        pc = UA_IGNORE;
        case (op)
            OP_EDGE:  pc = UA_EDGE;
            OP_READ:  pc = UA_READ;
            OP_START: pc = UA_START;
            default:  pc = UA_IGNORE;
        endcase
        return pc;
    endfunction

endpackage

[src/tach_intf.sv]
// valid/ready channel interfaces for command beats and result beats
interface tach_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [tach_pkg::TS_W-1:0]  timestamp_ms;

    modport source (output valid, output opcode, output timestamp_ms, input ready);
    modport sink   (input valid, input opcode, input timestamp_ms, output ready);
endinterface

interface tach_out_if;
    logic                        valid;
    logic                        ready;
    logic [tach_pkg::RPM_W-1:0]  average_rpm;
    logic [tach_pkg::RPM_W-1:0]  peak_rpm;

    modport source (output valid, output average_rpm, output peak_rpm, input ready);
    modport sink   (input valid, input average_rpm, input peak_rpm, output ready);
endinterface

[src/tachometer_rpm_statistics.sv]
// Period-measuring tachometer: each edge beat turns the time since the previous edge into
// rpm = 60000 / elapsed_ms / blade_count and folds it into a running sum, count and peak;
// a read beat returns the truncated mean and the peak (zeros with no readings) and clears
// them, and a start beat clears them and forgets the previous edge. One command is worked
// at a time by a small microcoded sequencer over a shared serial divider that yields one
// quotient bit per cycle. An edge with a known previous edge runs two 16-step divisions
// and a read with readings one 40-step division; the first edge after reset or start,
// a read with nothing counted, a start and an unused code run no division. Either read
// may also wait for the result register to drain. A finished result sits in an output
// register, so the next command is accepted while it waits.
// Blade count is written through i_cfg_we/i_cfg_wdata; the user must write it only while
// no command is in work, which the block does not enforce; a value of zero acts as one.
module tachometer_rpm_statistics (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tach_pkg::BLADE_W-1:0]   i_cfg_wdata,
    tach_in_if.sink                        i_item,
    tach_out_if.source                     o_result
);

    logic [tach_pkg::BLADE_W-1:0]     r_blades;
    logic [tach_pkg::TS_W-1:0]        r_prev;
    logic                             r_have;
    logic [tach_pkg::TS_W-1:0]        r_ts;
    logic [tach_pkg::TOTAL_W-1:0]     r_total;
    logic [tach_pkg::COUNT_WIDTH-1:0] r_count;
    logic [tach_pkg::RPM_W-1:0]       r_peak;
    logic                             r_out_valid;
    logic [tach_pkg::RPM_W-1:0]       r_out_avg;
    logic [tach_pkg::RPM_W-1:0]       r_out_peak;

    tach_pkg::t_seq_status            stat;
    tach_pkg::t_seq_ctrl              ctrl;
    tach_pkg::t_div_ctl               div_ctl;
    logic                             accept;
    logic [tach_pkg::TS_W-1:0]        elapsed;
    logic [tach_pkg::TOTAL_W-1:0]     dividend;
    logic [tach_pkg::DIV_W-1:0]       divisor;
    logic [tach_pkg::TOTAL_W-1:0]     quotient;
    logic [tach_pkg::RPM_W-1:0]       rpm;

    assign accept         = i_item.valid && i_item.ready;
    assign i_item.ready   = !ctrl.busy;
    assign o_result.valid       = r_out_valid;
    assign o_result.average_rpm = r_out_avg;
    assign o_result.peak_rpm    = r_out_peak;

    // status for conditional jumps
    always_comb begin
        stat.have_prev  = r_have;
        stat.count_zero = r_count == '0;
        stat.out_busy   = r_out_valid && !o_result.ready;
    end

    tach_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_opcode (i_item.opcode),
        .i_stat   (stat),
        .o_ctrl   (ctrl)
    );

    // divider operand selection
    always_comb begin
        elapsed = r_ts - r_prev;
        rpm     = quotient[tach_pkg::RPM_W-1:0];
        div_ctl.load = (ctrl.act == tach_pkg::ACT_LOAD_RPM) ||
                       (ctrl.act == tach_pkg::ACT_LOAD_BLADE) ||
                       (ctrl.act == tach_pkg::ACT_LOAD_AVG);
        div_ctl.step = ctrl.act == tach_pkg::ACT_DIV_STEP;
        case (ctrl.act)
            tach_pkg::ACT_LOAD_RPM: begin
                dividend = {tach_pkg::RPM_NUMERATOR, {tach_pkg::COUNT_WIDTH{1'b0}}};
                divisor  = (elapsed == '0) ? tach_pkg::DIV_W'(1) : tach_pkg::DIV_W'(elapsed);
            end
            tach_pkg::ACT_LOAD_BLADE: begin
                dividend = {rpm, {tach_pkg::COUNT_WIDTH{1'b0}}};
                divisor  = (r_blades == '0) ? tach_pkg::DIV_W'(1) : tach_pkg::DIV_W'(r_blades);
            end
            default: begin
                dividend = r_total;
                divisor  = tach_pkg::DIV_W'(r_count);
            end
        endcase
    end

    tach_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quotient (quotient)
    );

    // timestamp of the beat in work
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ts <= i_item.timestamp_ms;
        end
    end

    // blade count, edge memory and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blades <= tach_pkg::BLADE_RESET;
            r_prev   <= '0;
            r_have   <= 1'b0;
            r_total  <= '0;
            r_count  <= '0;
            r_peak   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_blades <= i_cfg_wdata;
            end
            case (ctrl.act)
                tach_pkg::ACT_ACCUM: begin
                    if (r_count != tach_pkg::COUNT_MAX) begin
                        r_count <= r_count + tach_pkg::COUNT_WIDTH'(1);
                        r_total <= r_total + tach_pkg::TOTAL_W'(rpm);
                    end
                    if (r_peak < rpm) begin
                        r_peak <= rpm;
                    end
                end
                tach_pkg::ACT_EDGE_TIME: begin
                    r_prev <= r_ts;
                    r_have <= 1'b1;
                end
                tach_pkg::ACT_START: begin
                    r_prev  <= '0;
                    r_have  <= 1'b0;
                    r_total <= '0;
                    r_count <= '0;
                    r_peak  <= '0;
                end
                tach_pkg::ACT_EMIT_AVG,
                tach_pkg::ACT_EMIT_ZERO: begin
                    r_total <= '0;
                    r_count <= '0;
                    r_peak  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((ctrl.act == tach_pkg::ACT_EMIT_AVG) ||
                     (ctrl.act == tach_pkg::ACT_EMIT_ZERO)) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.act == tach_pkg::ACT_EMIT_AVG) begin
            r_out_avg  <= rpm;
            r_out_peak <= r_peak;
        end else if (ctrl.act == tach_pkg::ACT_EMIT_ZERO) begin
            r_out_avg  <= '0;
            r_out_peak <= '0;
        end
    end

endmodule

[src/tach_div.sv]
// restoring serial divider, one quotient bit per step
module tach_div (
    input  logic                         i_clk,
    input  tach_pkg::t_div_ctl           i_ctl,
    input  logic [tach_pkg::TOTAL_W-1:0] i_dividend,
    input  logic [tach_pkg::DIV_W-1:0]   i_divisor,
    output logic [tach_pkg::TOTAL_W-1:0] o_quotient
);

    logic [tach_pkg::DIV_W-1:0]   r_rem;
    logic [tach_pkg::TOTAL_W-1:0] r_quo;
    logic [tach_pkg::DIV_W-1:0]   r_dvs;
    logic [tach_pkg::DIV_W:0]     rem_sh;
    logic [tach_pkg::DIV_W:0]     rem_sub;
    logic                         fits;

    // shift in the next dividend bit and trial subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[tach_pkg::TOTAL_W-1]};
        fits    = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (i_ctl.step) begin
            r_rem <= fits ? rem_sub[tach_pkg::DIV_W-1:0] : rem_sh[tach_pkg::DIV_W-1:0];
            r_quo <= {r_quo[tach_pkg::TOTAL_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;

endmodule

[src/tach_seq.sv]
// microcode sequencer: step counter, program rom, iteration counter and jumps
module tach_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_opcode,
    input  tach_pkg::t_seq_status i_stat,
    output tach_pkg::t_seq_ctrl   o_ctrl
);

    tach_pkg::t_seq_state         r_state, n_state;
    tach_pkg::t_upc               r_pc, n_pc;
    logic [tach_pkg::ITER_W-1:0]  r_iter, n_iter;
    tach_pkg::t_uword             word;
    logic                         stall;
    logic                         jump;

    // current control word and its jump condition
    always_comb begin
        word  = tach_pkg::ucode_rom(r_pc);
        stall = ((word.act == tach_pkg::ACT_EMIT_AVG) ||
                 (word.act == tach_pkg::ACT_EMIT_ZERO)) && i_stat.out_busy;
        case (word.cond)
            tach_pkg::CND_NO_PREV:    jump = !i_stat.have_prev;
            tach_pkg::CND_COUNT_ZERO: jump = i_stat.count_zero;
            tach_pkg::CND_ITER_MORE:  jump = r_iter != tach_pkg::ITER_W'(1);
            default:                  jump = 1'b0;
        endcase
    end

    // next step, iteration count and state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_iter  = r_iter;
        o_ctrl.act  = tach_pkg::ACT_NONE;
        o_ctrl.busy = r_state == tach_pkg::SQ_RUN;
        case (r_state)
            tach_pkg::SQ_IDLE: begin
                if (i_start) begin
                    n_state = tach_pkg::SQ_RUN;
                    n_pc    = tach_pkg::op_entry(tach_pkg::t_opcode'(i_opcode));
                end
            end
            tach_pkg::SQ_RUN: begin
                if (!stall) begin
                    o_ctrl.act = word.act;
                    case (word.act)
                        tach_pkg::ACT_LOAD_RPM,
                        tach_pkg::ACT_LOAD_BLADE: n_iter = tach_pkg::ITER_RPM;
                        tach_pkg::ACT_LOAD_AVG:   n_iter = tach_pkg::ITER_AVG;
                        tach_pkg::ACT_DIV_STEP:   n_iter = r_iter - tach_pkg::ITER_W'(1);
                        default:                  n_iter = r_iter;
                    endcase
                    if (jump) begin
                        n_pc = word.target;
                    end else if (word.last) begin
                        n_state = tach_pkg::SQ_IDLE;
                    end else begin
                        n_pc = r_pc + tach_pkg::UPC_W'(1);
                    end
                end
            end
            default: n_state = tach_pkg::SQ_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tach_pkg::SQ_IDLE;
            r_pc    <= tach_pkg::UA_EDGE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_iter  <= n_iter;
        end
    end

endmodule

[src/tach_checker.sv]
// port-level checks of the tachometer and their attachment to the top level
module tach_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tach_pkg::RPM_W-1:0] i_average_rpm,
    input logic [tach_pkg::RPM_W-1:0] i_peak_rpm
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_average_rpm) &&
        $stable(i_peak_rpm))
        else $error("result beat changed while stalled");

    // a mean never exceeds the peak it was taken with
    a_avg_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_average_rpm <= i_peak_rpm)
        else $error("average above peak");

    // rpm cannot exceed 60000, one revolution per millisecond
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_peak_rpm <= tach_pkg::RPM_NUMERATOR)
        else $error("peak rpm out of range");

    // one command at a time: no beat taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while another is in work");

endmodule

bind tachometer_rpm_statistics tach_checker u_tach_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_average_rpm (o_result.average_rpm),
    .i_peak_rpm    (o_result.peak_rpm)
);

[dv/tb_top.sv]
// self-checking testbench of the rpm statistics tachometer with a scoreboard class
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tach_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLE = 60;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 120;

    // one expected read report
    typedef struct packed {
        logic [RPM_W-1:0] average;
        logic [RPM_W-1:0] peak;
    } t_rpm_report;

    // predicts the statistics and holds the read reports still to come
    class rpm_scoreboard;
        logic [BLADE_W-1:0]     blades;
        logic [TS_W-1:0]        last_edge_ms;
        bit                     have_edge;
        logic [TOTAL_W-1:0]     rpm_sum;
        logic [COUNT_WIDTH-1:0] readings;
        logic [RPM_W-1:0]       peak;
        t_rpm_report            reports_due[$];
        int                     errors;

        function new();
            blades       = BLADE_RESET;
            last_edge_ms = '0;
            have_edge    = 1'b0;
            errors       = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            rpm_sum  = '0;
            readings = '0;
            peak     = '0;
        endfunction

        function void set_blades(logic [BLADE_W-1:0] value);
            blades = value;
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        // fold one accepted command beat into the predicted state
        function void note_command(t_opcode op, logic [TS_W-1:0] stamp);
            logic [TS_W-1:0] elapsed;
            logic [TS_W-1:0] divisor;
            logic [TS_W-1:0] rpm;
            t_rpm_report     rep;
            case (op)
                OP_EDGE: begin
                    if (have_edge) begin
                        // elapsed time wraps modulo 2^32, zero counts as one
                        elapsed = stamp - last_edge_ms;
                        if (elapsed == '0) elapsed = TS_W'(1);
                        divisor = (blades == '0) ? TS_W'(1) : TS_W'(blades);
                        rpm = (TS_W'(RPM_NUMERATOR) / elapsed) / divisor;
                        // saturated count freezes sum and count, not the peak
                        if (readings != COUNT_MAX) begin
                            readings = readings + COUNT_WIDTH'(1);
                            rpm_sum  = rpm_sum + TOTAL_W'(rpm);
                        end
                        if (peak < rpm[RPM_W-1:0]) peak = rpm[RPM_W-1:0];
                    end
                    last_edge_ms = stamp;
                    have_edge    = 1'b1;
                end
                OP_READ: begin
                    rep = '0;
                    if (readings != '0) begin
                        rep.average = RPM_W'(rpm_sum / TOTAL_W'(readings));
                        rep.peak    = peak;
                    end
                    reports_due.push_back(rep);
                    clear_stats();
                end
                OP_START: begin
                    clear_stats();
                    last_edge_ms = '0;
                    have_edge    = 1'b0;
                end
                default: begin
                end
            endcase
        endfunction

        // compare one result beat with the oldest expected report
        function void check_result(logic [RPM_W-1:0] average, logic [RPM_W-1:0] peak_rpm);
            t_rpm_report rep;
            if (reports_due.size() == 0) begin
                $error("result beat with no report expected: average_rpm %0d, peak_rpm %0d",
                       average, peak_rpm);
                errors++;
            end else begin
                rep = reports_due.pop_front();
                if (average !== rep.average) begin
                    $error("average_rpm mismatch: expected %0d, actual %0d",
                           rep.average, average);
                    errors++;
                end
                if (peak_rpm !== rep.peak) begin
                    $error("peak_rpm mismatch: expected %0d, actual %0d", rep.peak, peak_rpm);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [BLADE_W-1:0] i_cfg_wdata;

    tach_in_if  item_if ();
    tach_out_if result_if ();

    rpm_scoreboard sb = new();

    bit              idle_on;
    bit              hold_request;
    logic [TS_W-1:0] clock_ms;

    tachometer_rpm_statistics dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // offer one command beat and wait for it to be taken
    task automatic send_beat(input t_opcode op, input logic [TS_W-1:0] stamp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.opcode       <= op;
        item_if.timestamp_ms <= stamp;
        do @(posedge i_clk); while (!item_if.ready);
        sb.note_command(op, stamp);
    endtask

    // edge beat advanced from the running millisecond clock
    task automatic send_edge_after(input logic [TS_W-1:0] gap);
        clock_ms = clock_ms + gap;
        send_beat(OP_EDGE, clock_ms);
    endtask

    // wait until every report is back and the sequencer has gone quiet
    task automatic drain_and_settle();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLE) @(posedge i_clk);
    endtask

    task automatic write_blades(input logic [BLADE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_blades(value);
    endtask

    // mostly edge trains with realistic periods, some reads, starts and noise
    task automatic run_random(input int beats);
        int              left;
        int              pick;
        int              span;
        logic [TS_W-1:0] gap;
        left = beats;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                span = $urandom_range(0, 99);
                if (span < 60)      gap = $urandom_range(1, 300);
                else if (span < 75) gap = $urandom_range(300, 60000);
                else if (span < 85) gap = '0;
                else                gap = $urandom;
                send_edge_after(gap);
                left--;
            end else if (pick < 84) begin
                send_beat(OP_READ, $urandom);
                left--;
            end else if (pick < 90) begin
                send_beat(OP_START, $urandom);
                clock_ms = $urandom;
                left--;
            end else if (pick < 94) begin
                send_beat(OP_UNUSED, $urandom);
            end else begin
                clock_ms = $urandom;
                send_beat(OP_EDGE, clock_ms);
                left--;
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int   stall_left;
        int   hold_left;
        logic ready_next;
        stall_left = 0;
        hold_left  = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.average_rpm, result_if.peak_rpm);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            result_if.ready <= ready_next;
        end
    end

    // watchdog on cycles with no beat moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (item_if.valid && item_if.ready) ||
                (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial begin
        logic [BLADE_W-1:0] phase_blades [PHASES];
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_wdata          <= '0;
        item_if.valid        <= 1'b0;
        item_if.opcode       <= OP_EDGE;
        item_if.timestamp_ms <= '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        clock_ms     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset blade count, empty read, first edge, zero elapsed, wrap
        send_beat(OP_READ, '0);
        send_beat(OP_EDGE, 32'h0000_0000);
        send_beat(OP_EDGE, 32'h0000_0000);
        send_beat(OP_EDGE, 32'd1000);
        send_beat(OP_EDGE, 32'hFFFF_FFF0);
        send_beat(OP_EDGE, 32'h0000_0010);
        send_beat(OP_READ, '0);
        send_beat(OP_READ, 32'hFFFF_FFFF);
        send_beat(OP_EDGE, 32'h0000_0007);
        send_beat(OP_READ, '0);
        // start forgets the previous edge, unused code does nothing
        send_beat(OP_START, 32'hFFFF_FFFF);
        send_beat(OP_UNUSED, 32'hFFFF_FFFF);
        send_beat(OP_EDGE, 32'hFFFF_FFFF);
        send_beat(OP_EDGE, 32'h0000_0005);
        send_beat(OP_START, '0);
        send_beat(OP_READ, '0);
        drain_and_settle();

        // largest blade count
        write_blades(8'd255);
        clock_ms = 32'h8000_0000;
        send_beat(OP_EDGE, clock_ms);
        send_edge_after(32'd1);
        send_edge_after(32'd3);
        send_beat(OP_READ, '0);
        drain_and_settle();

        // blade count of zero acts as one
        write_blades(8'd0);
        send_edge_after(32'd100);
        send_edge_after(32'd0);
        send_beat(OP_READ, '0);
        drain_and_settle();

        phase_blades[0] = 8'd255;
        phase_blades[1] = 8'd1;
        phase_blades[2] = 8'd0;
        phase_blades[3] = BLADE_W'($urandom_range(2, 20));
        phase_blades[4] = BLADE_W'($urandom_range(1, 255));
        phase_blades[5] = BLADE_W'($urandom_range(2, 254));

        for (int ph = 0; ph < PHASES; ph++) begin
            write_blades(phase_blades[ph]);
            idle_on = (ph != 3) && (ph != PHASES - 1);
            if (ph == 1) begin
                // hold the result side so reads back up into the command side
                hold_request = 1'b1;
                send_beat(OP_EDGE, clock_ms);
                send_edge_after(32'd7);
                send_beat(OP_READ, '0);
                send_edge_after(32'd11);
                send_edge_after(32'd13);
                send_beat(OP_READ, '0);
                send_beat(OP_READ, '0);
                send_beat(OP_READ, '0);
            end
            run_random(PHASE_BEATS);
            drain_and_settle();
        end

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/tach_pkg.sv
src/tach_intf.sv
src/tach_div.sv
src/tach_seq.sv
src/tachometer_rpm_statistics.sv
src/tach_checker.sv
dv/tb_top.sv
